FILE: design/slfp_pkg.sv
package slfp_pkg;

    // Body buffer depth, its address width and the length and counter widths
    localparam int BODY_DEPTH = 64;
    localparam int ADDR_W     = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
    localparam int LEN_W      = 7;
    localparam int CNT_W      = 16;

    localparam logic [LEN_W-1:0] BODY_DEPTH_LEN = LEN_W'(BODY_DEPTH);

    // Register reset values
    localparam logic [7:0]       SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]       SYNC_SECOND_RST = 8'h55;
    localparam logic [LEN_W-1:0] MAX_LEN_RST     = 7'd48;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_BODY  = 3'd3,
        PH_SUM   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_INPUT = 2'd0,
        ST_READ  = 2'd1,
        ST_LOAD  = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        KIND_PROGRESS = 2'd0,
        KIND_LEN_ERR  = 2'd1,
        KIND_SUM_ERR  = 2'd2,
        KIND_BODY     = 2'd3
    } t_kind;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

endpackage

FILE: design/slfp_body_ram.sv
module slfp_body_ram
    import slfp_pkg::*;
(
    input  logic       i_clk,
    input  t_ram_req   i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [BODY_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/sync_length_sum_frame_parser_core.sv
// Sync / length / checksum frame parser.
// Input channel (i_in_valid / o_in_ready, i_rx_byte): one received byte per
// request. Output channel (o_out_valid / i_out_ready): result requests with
// kind, body byte, body index, last flag and both frame counters.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 first sync byte,
// 1 second sync byte, 2 max length; always ready, other indexes ignored.
// Every byte except a good checksum gives one status result, registered
// in the cycle after the byte is taken; the next byte can be taken in
// that cycle, so bytes flow at one per cycle while the receiver keeps up.
// A good checksum replays the stored body from the 64 x 8 body RAM:
// each body byte is read from the RAM in the read state and loaded into
// the output register in the load state, one byte after the other, and
// no input byte is taken until the last body result has been loaded.
// A stalled receiver holds the output register; no new byte is taken
// and the replay pauses until the pending result is taken.
// Reset (synchronous, active low) returns to sync hunting, clears both
// counters and restores the register defaults; the RAM is not cleared
// since no entry is read before it is written in the same frame.
module sync_length_sum_frame_parser_core
    import slfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_rx_byte,

    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_body_byte,
    output logic [5:0]       o_byte_index,
    output logic             o_last,
    output logic [CNT_W-1:0] o_good_frames,
    output logic [CNT_W-1:0] o_bad_frames,

    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    // config registers
    logic [7:0]       r_sync_first;
    logic [7:0]       r_sync_second;
    logic [LEN_W-1:0] r_max_len;

    // parser state
    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [CNT_W-1:0] r_frame_cnt, n_frame_cnt;
    logic [CNT_W-1:0] r_err_cnt, n_err_cnt;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;

    // output register
    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [7:0]       r_out_byte;
    logic [5:0]       r_out_index;
    logic             r_out_last;

    logic             in_fire;
    logic             out_free;
    logic             good_sum;
    logic             rd_last;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] pos_inc;
    t_kind            in_kind;
    t_ram_req         ram_req;
    logic [7:0]       rd_data;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_INPUT) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign limit    = (r_max_len > BODY_DEPTH_LEN) ? BODY_DEPTH_LEN : r_max_len;
    assign pos_inc  = r_pos + 7'd1;
    assign good_sum = (r_phase == PH_SUM) && (i_rx_byte == r_sum);
    assign rd_last  = (LEN_W'(r_rd_idx) == (r_len - 7'd1));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_max_len     <= MAX_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                CFG_MAX_LEN:     r_max_len     <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state of the replay sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INPUT: begin
                if (in_fire && good_sum) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                if (out_free) begin
                    n_state = rd_last ? ST_INPUT : ST_READ;
                end
            end
            default: n_state = ST_INPUT;
        endcase
    end

    // Byte parsing, counters and RAM requests
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_frame_cnt = r_frame_cnt;
        n_err_cnt   = r_err_cnt;
        n_rd_idx    = r_rd_idx;
        in_kind     = KIND_PROGRESS;

        ram_req         = '0;
        ram_req.wr_addr = r_pos[ADDR_W-1:0];
        ram_req.wr_data = i_rx_byte;
        ram_req.rd_addr = r_rd_idx;

        if (in_fire) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_rx_byte == r_sync_first) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_rx_byte == r_sync_second) begin
                        n_phase = PH_LEN;
                    end else if (i_rx_byte != r_sync_first) begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte == 8'd0 || i_rx_byte > {1'b0, limit}) begin
                        n_err_cnt = r_err_cnt + 16'd1;
                        in_kind   = KIND_LEN_ERR;
                        n_phase   = PH_SYNC1;
                    end else begin
                        n_len   = i_rx_byte[LEN_W-1:0];
                        n_pos   = '0;
                        n_sum   = i_rx_byte;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    ram_req.wr_en = (r_pos < BODY_DEPTH_LEN);
                    n_pos = pos_inc;
                    n_sum = r_sum + i_rx_byte;
                    if (pos_inc >= r_len) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_phase = PH_SYNC1;
                    if (good_sum) begin
                        n_frame_cnt = r_frame_cnt + 16'd1;
                        n_rd_idx    = '0;
                    end else begin
                        n_err_cnt = r_err_cnt + 16'd1;
                        in_kind   = KIND_SUM_ERR;
                    end
                end
                default: n_phase = PH_SYNC1;
            endcase
        end

        if (r_state == ST_READ) begin
            ram_req.rd_en = 1'b1;
        end
        if (r_state == ST_LOAD && out_free && !rd_last) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INPUT;
            r_phase     <= PH_SYNC1;
            r_len       <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_frame_cnt <= '0;
            r_err_cnt   <= '0;
            r_rd_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_frame_cnt <= n_frame_cnt;
            r_err_cnt   <= n_err_cnt;
            r_rd_idx    <= n_rd_idx;
        end
    end

    // Output register: status result on a byte other than a good checksum, body on replay
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && !good_sum) begin
            r_out_valid <= 1'b1;
        end else if (r_state == ST_LOAD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !good_sum) begin
            r_out_kind  <= in_kind;
            r_out_byte  <= '0;
            r_out_index <= '0;
            r_out_last  <= 1'b1;
        end else if (r_state == ST_LOAD && out_free) begin
            r_out_kind  <= KIND_BODY;
            r_out_byte  <= rd_data;
            r_out_index <= 6'(r_rd_idx);
            r_out_last  <= rd_last;
        end
    end

    slfp_body_ram u_body_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_body_byte   = r_out_byte;
    assign o_byte_index  = r_out_index;
    assign o_last        = r_out_last;
    assign o_good_frames = r_frame_cnt;
    assign o_bad_frames  = r_err_cnt;

    // good checksum starts a replay and bumps the frame count once
    a_good_starts_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && good_sum |=> r_state == ST_READ
            && r_frame_cnt == $past(r_frame_cnt) + 16'd1)
        else $error("good checksum did not start replay");

    // while replaying, the parser is back to hunting and counters hold
    a_replay_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_INPUT |-> r_phase == PH_SYNC1 && !o_in_ready)
        else $error("input taken during replay");

    a_replay_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |=> $stable(r_frame_cnt) && $stable(r_err_cnt))
        else $error("counter moved during replay");

    // last body result ends the replay
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD && out_free && rd_last |=> r_state == ST_INPUT
            && r_out_valid && r_out_last)
        else $error("replay end mismatch");

    // a stored length always fits the body RAM
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY || r_state != ST_INPUT |-> r_len != 7'd0
            && r_len <= BODY_DEPTH_LEN)
        else $error("frame length out of range");

endmodule
